// ===== rtl/assert_macros.svh =====
// assertion macros used by the top level rtl file
// no dependencies; the checks drop out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define VAF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define VAF_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VAF_ASSERT(label, clk, rst, prop, msg)
`define VAF_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/vaf_pkg.sv =====
// shared types, codes and helper functions of the attribute converter
// no dependencies
package vaf_pkg;

   typedef enum logic [2:0] {
      FMT_S8      = 3'd0,
      FMT_U8      = 3'd1,
      FMT_S16     = 3'd2,
      FMT_U16     = 3'd3,
      FMT_S32     = 3'd4,
      FMT_U32     = 3'd5,
      FMT_FLOAT   = 3'd6,
      FMT_INVALID = 3'd7
   } fmt_type;

   localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
   localparam logic [30:0] INF_BITS  = 31'h7F80_0000;

   // converted value and multiplier
   typedef struct packed {
      logic        bad;
      logic [31:0] value;
      logic [31:0] scale;
   } conv_type;

   // raw mantissa product
   typedef struct packed {
      logic        bad;
      logic        special;
      logic [31:0] special_bits;
      logic        sign;
      logic [8:0]  exp_sum;
      logic [47:0] prod;
   } prod_type;

   // product with leading one at the top bit
   typedef struct packed {
      logic               bad;
      logic               special;
      logic [31:0]        special_bits;
      logic               sign;
      logic signed [10:0] biased;
      logic [47:0]        norm;
   } norm_type;

   function automatic logic [5:0] lzc32(input logic [31:0] v);
      logic [5:0] n;
      n = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) n = 6'(31 - i);
      end
      return n;
   endfunction

   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] n;
      n = 6'd48;
      for (int i = 0; i < 48; i++) begin
         if (v[i]) n = 6'(47 - i);
      end
      return n;
   endfunction

endpackage

// ===== rtl/vaf_cvt.sv =====
// integer or float attribute word to single precision, round to nearest even
// depends on vaf_pkg
module vaf_cvt
   import vaf_pkg::*;
(
   input  logic [31:0] raw_value,
   input  logic [2:0]  value_type,
   input  logic [31:0] scale_bits,
   output conv_type    conv
);

   fmt_type     fmt;
   logic        neg;
   logic [31:0] mag;
   logic [5:0]  lz;
   logic [31:0] n;
   logic        rup;
   logic [24:0] r;
   logic [7:0]  ex;
   logic [31:0] int_bits;

   assign fmt = fmt_type'(value_type);

   always_comb begin
      neg = 1'b0;
      mag = 32'd0;
      unique case (fmt)
         FMT_S8: begin
            neg = raw_value[7];
            mag = neg ? {24'd0, 8'(~raw_value[7:0] + 8'd1)} : {24'd0, raw_value[7:0]};
         end
         FMT_U8:  mag = {24'd0, raw_value[7:0]};
         FMT_S16: begin
            neg = raw_value[15];
            mag = neg ? {16'd0, 16'(~raw_value[15:0] + 16'd1)} : {16'd0, raw_value[15:0]};
         end
         FMT_U16: mag = {16'd0, raw_value[15:0]};
         FMT_S32: begin
            neg = raw_value[31];
            mag = neg ? (~raw_value + 32'd1) : raw_value;
         end
         FMT_U32: mag = raw_value;
         default: mag = 32'd0;
      endcase
   end

   assign lz  = lzc32(mag);
   assign n   = mag << lz;
   assign rup = n[7] & ((|n[6:0]) | n[8]);
   assign r   = {1'b0, n[31:8]} + {24'd0, rup};
   // leading one at bit 31 means exponent 31, bias 127
   assign ex  = 8'(8'd158 - {2'b0, lz}) + {7'd0, r[24]};
   assign int_bits = (mag == 32'd0) ? 32'd0 : {neg, ex, r[22:0]};

   always_comb begin
      conv.scale = scale_bits;
      conv.bad   = (fmt == FMT_INVALID);
      unique case (fmt)
         FMT_FLOAT:   conv.value = raw_value;
         FMT_INVALID: conv.value = 32'd0;
         default:     conv.value = int_bits;
      endcase
   end

endmodule

// ===== rtl/vaf_mul.sv =====
// operand unpack, special cases and 24x24 mantissa multiply
// depends on vaf_pkg
module vaf_mul
   import vaf_pkg::*;
(
   input  conv_type conv,
   output prod_type prod
);

   logic [7:0]  ea, eb;
   logic [22:0] fa, fb;
   logic        za, zb, na, nb, ia, ib, sign;
   logic [23:0] ma, mb;
   logic [7:0]  ea_eff, eb_eff;

   assign sign = conv.value[31] ^ conv.scale[31];
   assign ea = conv.value[30:23];
   assign eb = conv.scale[30:23];
   assign fa = conv.value[22:0];
   assign fb = conv.scale[22:0];
   assign za = (ea == 8'd0) && (fa == 23'd0);
   assign zb = (eb == 8'd0) && (fb == 23'd0);
   assign na = (ea == 8'hFF) && (fa != 23'd0);
   assign nb = (eb == 8'hFF) && (fb != 23'd0);
   assign ia = (ea == 8'hFF);
   assign ib = (eb == 8'hFF);

   // subnormals use exponent one and no hidden bit
   assign ma     = {(ea != 8'd0), fa};
   assign mb     = {(eb != 8'd0), fb};
   assign ea_eff = (ea == 8'd0) ? 8'd1 : ea;
   assign eb_eff = (eb == 8'd0) ? 8'd1 : eb;

   always_comb begin
      prod.bad          = conv.bad;
      prod.sign         = sign;
      prod.exp_sum      = {1'b0, ea_eff} + {1'b0, eb_eff};
      prod.prod         = {24'd0, ma} * {24'd0, mb};
      prod.special      = 1'b1;
      prod.special_bits = {sign, 31'd0};
      priority if (conv.bad)   prod.special_bits = 32'd0;
      else if (na || nb)       prod.special_bits = QNAN_BITS;
      else if (ia || ib)       prod.special_bits = (za || zb) ? QNAN_BITS : {sign, INF_BITS};
      else if (za || zb)       prod.special_bits = {sign, 31'd0};
      else                     prod.special      = 1'b0;
   end

endmodule

// ===== rtl/vaf_nrm.sv =====
// leading zero count and left normalize of the mantissa product
// depends on vaf_pkg
module vaf_nrm
   import vaf_pkg::*;
(
   input  prod_type prod,
   output norm_type norm
);

   logic [5:0] lz;

   assign lz = lzc48(prod.prod);

   always_comb begin
      norm.bad          = prod.bad;
      norm.special      = prod.special;
      norm.special_bits = prod.special_bits;
      norm.sign         = prod.sign;
      norm.norm         = prod.prod << lz;
      // leading one at bit 47: biased exponent is ea + eb - 126 - lz
      norm.biased       = $signed({2'b00, prod.exp_sum}) - 11'sd126 - $signed({5'd0, lz});
   end

endmodule

// ===== rtl/vaf_rnd.sv =====
// denormalize, round to nearest even and pack the product
// depends on vaf_pkg
module vaf_rnd
   import vaf_pkg::*;
(
   input  norm_type    norm,
   output logic [31:0] result_bits,
   output logic        bad_type
);

   logic               tiny;
   logic [10:0]        sh_full;
   logic [5:0]         sh;
   logic [47:0]        nd;
   logic               lost, rup;
   logic [23:0]        q;
   logic [24:0]        r;
   logic signed [10:0] ex;
   logic [31:0]        packed_bits;

   assign tiny    = (norm.biased < 11'sd1);
   assign sh_full = 11'(11'sd1 - norm.biased);
   assign sh      = !tiny ? 6'd0 : ((sh_full >= 11'd48) ? 6'd48 : sh_full[5:0]);
   assign nd      = norm.norm >> sh;
   assign lost    = |(norm.norm & ~(48'hFFFF_FFFF_FFFF << sh));
   assign q       = nd[47:24];
   assign rup     = nd[23] & ((|nd[22:0]) | lost | q[0]);
   assign r       = {1'b0, q} + {24'd0, rup};
   assign ex      = norm.biased + $signed({10'd0, r[24]});

   always_comb begin
      if (tiny) begin
         // rounding up into bit 23 lands on the smallest normal
         packed_bits = {norm.sign, 7'd0, r[23], r[22:0]};
      end else if (ex >= 11'sd255) begin
         packed_bits = {norm.sign, INF_BITS};
      end else begin
         packed_bits = {norm.sign, ex[7:0], r[22:0]};
      end
   end

   assign result_bits = norm.special ? norm.special_bits : packed_bits;
   assign bad_type    = norm.bad;

endmodule

// ===== rtl/vertex_attribute_to_float_scale.sv =====
// top level: five stage pipeline converting an attribute word and scaling it
// depends on vaf_pkg, vaf_cvt, vaf_mul, vaf_nrm, vaf_rnd, assert_macros.svh
// Takes one beat per cycle while req_stall is low and returns one result
// beat per input beat, in order. The registers are the input register,
// integer to float conversion, 24x24 mantissa multiply, product normalize,
// and round and pack into the output register. Each stage moves on when
// the one after it is empty or moving, so bubbles close up and rsp_stall
// reaches req_stall only when every stage holds a beat. Unknown format
// codes give result zero with rsp_bad_type set; all NaN results are the
// quiet NaN 0x7FC00000.
`include "assert_macros.svh"
module vertex_attribute_to_float_scale
   import vaf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_raw_value,
   input  logic [2:0]  req_value_type,
   input  logic [31:0] req_scale_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_bits,
   output logic        rsp_bad_type
);

   logic [4:0]  v_ff, v_in;
   logic [4:0]  adv;
   logic [31:0] raw_ff, scale_ff;
   logic [2:0]  type_ff;
   conv_type    conv_c, conv_ff;
   prod_type    prod_c, prod_ff;
   norm_type    norm_c, norm_ff;
   logic [31:0] res_c, res_ff;
   logic        bad_c, bad_ff;

   always_comb begin
      adv[4] = !v_ff[4] || !rsp_stall;
      for (int i = 3; i >= 0; i--) begin
         adv[i] = !v_ff[i] || adv[i + 1];
      end
   end

   assign req_stall = !adv[0];

   always_comb begin
      v_in = v_ff;
      if (adv[0]) v_in[0] = req_valid;
      for (int i = 1; i < 5; i++) begin
         if (adv[i]) v_in[i] = v_ff[i - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 5'd0;
      end else begin
         v_ff <= v_in;
      end
   end

   vaf_cvt u_cvt (
      .raw_value  (raw_ff),
      .value_type (type_ff),
      .scale_bits (scale_ff),
      .conv       (conv_c)
   );

   vaf_mul u_mul (
      .conv (conv_ff),
      .prod (prod_c)
   );

   vaf_nrm u_nrm (
      .prod (prod_ff),
      .norm (norm_c)
   );

   vaf_rnd u_rnd (
      .norm        (norm_ff),
      .result_bits (res_c),
      .bad_type    (bad_c)
   );

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         raw_ff   <= req_raw_value;
         type_ff  <= req_value_type;
         scale_ff <= req_scale_bits;
      end
      if (adv[1]) conv_ff <= conv_c;
      if (adv[2]) prod_ff <= prod_c;
      if (adv[3]) norm_ff <= norm_c;
      if (adv[4]) begin
         res_ff <= res_c;
         bad_ff <= bad_c;
      end
   end

   assign rsp_valid       = v_ff[4];
   assign rsp_result_bits = res_ff;
   assign rsp_bad_type    = bad_ff;

   `VAF_ASSERT(a_bad_zero, clock, reset, rsp_valid && rsp_bad_type |-> rsp_result_bits == 32'd0, "bad format beat with nonzero result")
   `VAF_ASSERT(a_stall_src, clock, reset, req_stall |-> rsp_valid && rsp_stall && (&v_ff), "input stalled without full pipeline")
   `VAF_ASSERT_NR(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "result valid right after reset")

endmodule

// ===== tb/vertex_attribute_to_float_scale_tb.sv =====
// testbench of the attribute converter: directed and random beats against a
// bit-exact float predictor, checked in order by a small scoreboard class
// depends on vaf_pkg and the vertex_attribute_to_float_scale rtl
module vertex_attribute_to_float_scale_tb;
   import vaf_pkg::*;

   localparam int NUM_RANDOM = 850;
   localparam int PIPE_DEPTH = 5;

   // rounds sig * 2^exp2 to single precision, nearest even, with subnormals
   function automatic logic [31:0] pack_single(logic sign, logic [63:0] sig, int exp2);
      int msb;
      int sh;
      int biased;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      msb = 63;
      while (!sig[msb]) msb--;
      sh = msb - 23;
      if (sh < -149 - exp2) sh = -149 - exp2;
      if (sh > 62) begin
         q = 64'd0;
      end else if (sh > 0) begin
         rem = sig & ((64'd1 << sh) - 64'd1);
         half = 64'd1 << (sh - 1);
         q = sig >> sh;
         if (rem > half || (rem == half && q[0])) q++;
      end else begin
         q = sig << (-sh);
      end
      if (q >= (64'd1 << 24)) begin
         q = q >> 1;
         sh++;
      end
      if (q >= (64'd1 << 23)) begin
         biased = sh + exp2 + 150;
         if (biased >= 255) return {sign, INF_BITS};
         return {sign, biased[7:0], q[22:0]};
      end
      return {sign, q[30:0]};
   endfunction

   function automatic logic [31:0] int_as_single(logic neg, logic [31:0] mag);
      if (mag == 0) return 32'd0;
      return pack_single(neg, {32'd0, mag}, 0);
   endfunction

   function automatic logic [31:0] single_mul(logic [31:0] a, logic [31:0] b);
      logic sign;
      int ea;
      int eb;
      logic [23:0] ma;
      logic [23:0] mb;
      logic za;
      logic zb;
      sign = a[31] ^ b[31];
      ea = int'(a[30:23]);
      eb = int'(b[30:23]);
      ma = {1'b0, a[22:0]};
      mb = {1'b0, b[22:0]};
      za = (ea == 0 && ma == 0);
      zb = (eb == 0 && mb == 0);
      if ((ea == 255 && ma != 0) || (eb == 255 && mb != 0)) return QNAN_BITS;
      if (ea == 255 || eb == 255) begin
         if (za || zb) return QNAN_BITS;
         return {sign, INF_BITS};
      end
      if (za || zb) return {sign, 31'd0};
      if (ea == 0) ea = 1; else ma[23] = 1'b1;
      if (eb == 0) eb = 1; else mb[23] = 1'b1;
      return pack_single(sign, 64'(ma) * 64'(mb), ea + eb - 300);
   endfunction

   // expected scaled value of one attribute beat
   function automatic logic [32:0] scaled_attribute(logic [31:0] raw, fmt_type fmt,
                                                     logic [31:0] scale);
      logic [31:0] v;
      case (fmt)
         FMT_S8: v = raw[7] ? int_as_single(1'b1, 32'h100 - {24'd0, raw[7:0]})
                            : int_as_single(1'b0, {24'd0, raw[7:0]});
         FMT_U8: v = int_as_single(1'b0, {24'd0, raw[7:0]});
         FMT_S16: v = raw[15] ? int_as_single(1'b1, 32'h10000 - {16'd0, raw[15:0]})
                              : int_as_single(1'b0, {16'd0, raw[15:0]});
         FMT_U16: v = int_as_single(1'b0, {16'd0, raw[15:0]});
         FMT_S32: v = raw[31] ? int_as_single(1'b1, ~raw + 32'd1)
                              : int_as_single(1'b0, raw);
         FMT_U32: v = int_as_single(1'b0, raw);
         FMT_FLOAT: v = raw;
         default: return {1'b1, 32'd0};
      endcase
      return {1'b0, single_mul(v, scale)};
   endfunction

   class attr_scoreboard;
      logic [32:0] pending[$];
      int errors;

      function void note_beat(logic [31:0] raw, fmt_type fmt, logic [31:0] scale);
         pending.push_back(scaled_attribute(raw, fmt, scale));
      endfunction

      function void check_result(logic [31:0] bits, logic bad);
         logic [32:0] exp_r;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h bad %b", $time, bits, bad);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (exp_r[31:0] !== bits) begin
            $display("%0t: result_bits expected %h actual %h", $time, exp_r[31:0], bits);
            errors++;
         end
         if (exp_r[32] !== bad) begin
            $display("%0t: bad_type expected %b actual %b", $time, exp_r[32], bad);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_raw_value;
   logic [2:0]  req_value_type;
   logic [31:0] req_scale_bits;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_result_bits;
   logic        rsp_bad_type;

   attr_scoreboard board;
   bit          quiet_phase;   // no idling on either side
   bit          hold_off;      // long receiver stall
   bit          hold_start;

   vertex_attribute_to_float_scale dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_raw_value(req_raw_value), .req_value_type(req_value_type),
      .req_scale_bits(req_scale_bits),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_bits(rsp_result_bits), .rsp_bad_type(rsp_bad_type)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #20_000_000;
      $display("vertex_attribute_to_float_scale regression: fail");
      $finish;
   end

   // offers one beat, optionally after an idle gap, and waits for acceptance
   task automatic send_beat(logic [31:0] raw, fmt_type fmt, logic [31:0] scale);
      while (!quiet_phase && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_value <= raw;
      req_value_type <= fmt;
      req_scale_bits <= scale;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_beat(raw, fmt, scale);
   endtask

   function automatic logic [31:0] random_single();
      case ($urandom_range(5))
         0: return {1'($urandom_range(1)), 8'hFF,
                    ($urandom_range(1) ? 23'd0 : 23'($urandom))};
         1: return {1'($urandom_range(1)), 8'h00, 23'($urandom)};
         2: return {1'($urandom_range(1)), 8'($urandom_range(100, 154)), 23'($urandom)};
         3: return {1'($urandom_range(1)), 8'($urandom_range(1, 30)), 23'($urandom)};
         4: return {1'($urandom_range(1)), 8'($urandom_range(225, 254)), 23'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // response side: random stalls, checks on each accepted beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_result_bits, rsp_bad_type);
      rsp_stall <= hold_off || (!quiet_phase && $urandom_range(99) < 27);
   end

   // long receiver hold-off, counted in cycles
   initial begin
      hold_off = 1'b0;
      wait (hold_start);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (60) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      logic [31:0] raw;
      logic [31:0] scale;
      int waited;
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_raw_value = '0;
      req_value_type = FMT_S8;
      req_scale_bits = '0;
      quiet_phase = 1'b0;
      hold_start = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, each format, nan, inf, zero, under/overflow
      send_beat(32'h0000_0080, FMT_S8, 32'h3F80_0000);
      send_beat(32'hFFFF_FF7F, FMT_S8, 32'hBF80_0000);
      send_beat(32'hFFFF_FFFF, FMT_U8, 32'h3F80_0000);
      send_beat(32'h0000_8000, FMT_S16, 32'h3F00_0000);
      send_beat(32'h0000_FFFF, FMT_U16, 32'h4000_0000);
      send_beat(32'h8000_0000, FMT_S32, 32'h3F80_0000);
      send_beat(32'h7FFF_FFFF, FMT_S32, 32'h3F80_0000);
      send_beat(32'hFFFF_FFFF, FMT_U32, 32'h3F80_0000);
      send_beat(32'h0100_0001, FMT_U32, 32'h3F80_0000);
      send_beat(32'h0000_0000, FMT_S32, 32'hBF80_0000);
      send_beat(32'h7F80_0001, FMT_FLOAT, 32'h3F80_0000);
      send_beat(32'h3F80_0000, FMT_FLOAT, 32'hFFFF_FFFF);
      send_beat(32'h7F80_0000, FMT_FLOAT, 32'h0000_0000);
      send_beat(32'hFF80_0000, FMT_FLOAT, 32'h4000_0000);
      send_beat(32'h7F7F_FFFF, FMT_FLOAT, 32'h7F7F_FFFF);
      send_beat(32'h0000_0001, FMT_FLOAT, 32'h3F00_0000);
      send_beat(32'h0080_0000, FMT_FLOAT, 32'hBF00_0001);
      send_beat(32'h0000_0001, FMT_FLOAT, 32'h3FC0_0000);
      send_beat(32'hFFFF_FFFF, FMT_INVALID, 32'hFFFF_FFFF);
      send_beat(32'h0000_0000, FMT_INVALID, 32'h0000_0000);

      for (int i = 0; i < NUM_RANDOM; i++) begin
         quiet_phase = (i >= 300 && i < 400);
         if (i == 500) hold_start = 1'b1;
         raw = ($urandom_range(3) == 0) ? random_single() : $urandom;
         scale = random_single();
         send_beat(raw, fmt_type'($urandom_range(7)), scale);
      end
      req_valid <= 1'b0;

      waited = 0;
      while (board.pending.size() != 0 && waited < 10000) begin
         @(posedge clock);
         waited++;
      end
      repeat (PIPE_DEPTH * 4) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("vertex_attribute_to_float_scale regression: pass");
      end else begin
         $display("vertex_attribute_to_float_scale regression: fail");
      end
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/vaf_pkg.sv
rtl/vaf_cvt.sv
rtl/vaf_mul.sv
rtl/vaf_nrm.sv
rtl/vaf_rnd.sv
rtl/vertex_attribute_to_float_scale.sv
tb/vertex_attribute_to_float_scale_tb.sv
